// ===== hw/rtl/box_blur_3x3_edge_averaged_macros.svh =====
// Assertion macros for the 3x3 box blur block.
// Included by the top level; depends on nothing else.
`ifndef BOX_BLUR_3X3_EDGE_AVERAGED_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGED_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BB3_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bb3_pkg.sv =====
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// No dependencies; used by the top level, the sequencer and the datapath.
package bb3_pkg;

  // Line buffer geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Field and register widths
  localparam int FW_W      = 11;
  localparam int FH_W      = 16;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Mean arithmetic: sum of up to nine channels, count 1..9
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int NUM_W       = SUM_W + 1;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
  localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Line buffer read address source
  typedef enum logic [1:0] {
    ADDR_COL,
    ADDR_PREV,
    ADDR_CUR,
    ADDR_NEXT
  } addr_sel_t;

  // Which neighbourhood the sum stage takes
  typedef enum logic [1:0] {
    RES_FIRST,
    RES_SECOND,
    RES_DRAIN
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept_pix;
    addr_sel_t addr_sel;
    logic      win_shift;
    logic      ram_wr;
    logic      sum_load;
    res_sel_t  res_sel;
    logic      mul_load;
    logic      out_load;
    logic      adv_pixel;
    logic      adv_drain;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out1_en;
    logic out2_en;
    logic drain_ok;
    logic out_free;
  } dp_status_t;

  // ceil(2^17 / (2*count)); exact quotient for every numerator of the mean
  function automatic logic [RECIP_W-1:0] mean_recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      CNT_W'(1): m = RECIP_W'(65536);
      CNT_W'(2): m = RECIP_W'(32768);
      CNT_W'(3): m = RECIP_W'(21846);
      CNT_W'(4): m = RECIP_W'(16384);
      CNT_W'(5): m = RECIP_W'(13108);
      CNT_W'(6): m = RECIP_W'(10923);
      CNT_W'(7): m = RECIP_W'(9363);
      CNT_W'(8): m = RECIP_W'(8192);
      CNT_W'(9): m = RECIP_W'(7282);
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/box_blur_3x3_edge_averaged.sv =====
// Top level of the 3x3 box blur with edge-averaged borders.
// Depends on bb3_pkg, bb3_ctrl, bb3_datapath and the assertion macros header.
//
// Usage:
//  - Input channel (in_valid/in_stall): mode 0 carries an RGB pixel in raster
//    order; mode 1 is a drain request that returns the next last-row pixel.
//  - Result channel (out_valid/out_stall): one mean per transfer; out_last
//    marks the final result an input item causes (a row end gives two).
//  - Config channel (cfg_valid/cfg_ready, always ready): index 0 frame width,
//    index 1 frame height; any write restarts the frame. Write only when idle.
//  - Each result passes the registered line buffer read, the window, the sum
//    and the multiply registers before the output register. A drain with
//    nothing to give returns no result and leaves the block ready.
//  - The next item is taken as soon as the sequencer is back in idle, while
//    the last result may still sit in the output register.
//  - If the receiver stalls, the result holds in the output register and the
//    sequencer waits before loading another one.
//  - Reset (rst_n low, synchronous) clears the counters and valid flags and
//    sets width 640, height 480; line buffer contents are undefined.
`include "box_blur_3x3_edge_averaged_macros.svh"

module box_blur_3x3_edge_averaged (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [bb3_pkg::CH_W-1:0]      in_red_in,
  input  logic [bb3_pkg::CH_W-1:0]      in_green_in,
  input  logic [bb3_pkg::CH_W-1:0]      in_blue_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bb3_pkg::CH_W-1:0]      out_red_out,
  output logic [bb3_pkg::CH_W-1:0]      out_green_out,
  output logic [bb3_pkg::CH_W-1:0]      out_blue_out,
  output logic                          out_last,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_DAT_W-1:0] cfg_data
);

  import bb3_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  bb3_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_last      (out_last)
  );

  // a result is only loaded into a free output register
  `BB3_ASSERT_IMPLIES(a_out_load_free, clk, rst_n, cmd.out_load, (!out_valid || !out_stall), "output register overwritten")

  // a pixel transfer always occupies the sequencer
  `BB3_ASSERT_NEXT(a_pixel_busy, clk, rst_n, (in_valid && !in_stall && (in_mode == MODE_PIXEL)), in_stall, "pixel transfer did not start work")

  // a drain with nothing to give leaves the block ready
  `BB3_ASSERT_NEXT(a_drain_reject, clk, rst_n, (in_valid && !in_stall && (in_mode == MODE_DRAIN) && !status.drain_ok), !in_stall, "empty drain held the block")

  // a loaded result is presented next cycle
  `BB3_ASSERT_NEXT(a_out_shown, clk, rst_n, cmd.out_load, out_valid, "loaded result not presented")

endmodule

// ===== hw/rtl/bb3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
// Sequencer of the 3x3 box blur: steps each item through read and window and,
// where a result is due, sum, multiply and output. Depends on bb3_pkg.
module bb3_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_mode,
  output logic                   in_stall,
  input  bb3_pkg::dp_status_t    status,
  output bb3_pkg::ctrl_cmd_t     cmd
);

  import bb3_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WIN,
    ST_DR_PREV,
    ST_DR_CUR,
    ST_DR_NEXT,
    ST_DR_WIN,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   is_drain_r, is_drain_nxt;
  logic   second_r, second_nxt;
  logic   stall_r, stall_nxt;
  logic   accept;

  assign in_stall = stall_r;
  assign accept   = in_valid && !stall_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    is_drain_nxt = is_drain_r;
    second_nxt   = second_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_COL;
    cmd.res_sel  = RES_FIRST;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_PIXEL) begin
            cmd.accept_pix = 1'b1;
            is_drain_nxt   = 1'b0;
            state_nxt      = ST_PIX_RD;
          end else if (status.drain_ok) begin
            is_drain_nxt = 1'b1;
            state_nxt    = ST_DR_PREV;
          end
        end
      end
      ST_PIX_RD: begin
        cmd.addr_sel = ADDR_COL;
        state_nxt    = ST_PIX_WIN;
      end
      ST_PIX_WIN: begin
        cmd.win_shift = 1'b1;
        cmd.ram_wr    = 1'b1;
        if (status.out1_en) begin
          second_nxt = 1'b0;
          state_nxt  = ST_SUM;
        end else if (status.out2_en) begin
          second_nxt = 1'b1;
          state_nxt  = ST_SUM;
        end else begin
          cmd.adv_pixel = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      // drain: fetch columns c-1, c, c+1 of both line buffers
      ST_DR_PREV: begin
        cmd.addr_sel = ADDR_PREV;
        state_nxt    = ST_DR_CUR;
      end
      ST_DR_CUR: begin
        cmd.addr_sel  = ADDR_CUR;
        cmd.win_shift = 1'b1;
        state_nxt     = ST_DR_NEXT;
      end
      ST_DR_NEXT: begin
        cmd.addr_sel  = ADDR_NEXT;
        cmd.win_shift = 1'b1;
        state_nxt     = ST_DR_WIN;
      end
      ST_DR_WIN: begin
        cmd.win_shift = 1'b1;
        state_nxt     = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_load = 1'b1;
        if (is_drain_r) begin
          cmd.res_sel = RES_DRAIN;
        end else if (second_r) begin
          cmd.res_sel = RES_SECOND;
        end else begin
          cmd.res_sel = RES_FIRST;
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (!is_drain_r && !second_r && status.out2_en) begin
            second_nxt = 1'b1;
            state_nxt  = ST_SUM;
          end else begin
            cmd.adv_pixel = !is_drain_r;
            cmd.adv_drain = is_drain_r;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    stall_nxt = (state_nxt != ST_IDLE);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      is_drain_r <= 1'b0;
      second_r   <= 1'b0;
      stall_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      is_drain_r <= is_drain_nxt;
      second_r   <= second_nxt;
      stall_r    <= stall_nxt;
    end
  end

endmodule

// ===== hw/rtl/bb3_datapath.sv =====
// Datapath of the 3x3 box blur: registers, frame counters, line buffers,
// window, masked sum, reciprocal multiply and output register.
// Depends on bb3_pkg and bb3_ram.
module bb3_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bb3_pkg::ctrl_cmd_t               cmd,
  output bb3_pkg::dp_status_t              status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bb3_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic [bb3_pkg::CH_W-1:0]         in_red_in,
  input  logic [bb3_pkg::CH_W-1:0]         in_green_in,
  input  logic [bb3_pkg::CH_W-1:0]         in_blue_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bb3_pkg::CH_W-1:0]         out_red_out,
  output logic [bb3_pkg::CH_W-1:0]         out_green_out,
  output logic [bb3_pkg::CH_W-1:0]         out_blue_out,
  output logic                             out_last
);

  import bb3_pkg::*;

  // configuration and frame position
  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;
  logic [ADDR_W-1:0] col_r;
  logic [FH_W-1:0]   row_r;
  logic [ADDR_W-1:0] drn_r;
  logic [FW_W-1:0]   eff_w;
  logic [FH_W-1:0]   eff_h;
  logic [FW_W-1:0]   col_ext, col_inc, drn_ext, drn_inc;
  logic              row_end, col_wrap, drn_wrap, cfg_wr;

  // line buffers and window
  logic [PIX_W-1:0]  pix_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  older_rd, newer_rd;
  logic [PIX_W-1:0]  win_r [3][3];
  logic [PIX_W-1:0]  col_in [3];

  // mean pipeline
  logic [2:0]         rows_m, cols_m;
  logic               last_m;
  logic [SUM_W-1:0]   sum_nxt [3];
  logic [CNT_W-1:0]   cnt_nxt;
  logic [SUM_W-1:0]   sum_r [3];
  logic [CNT_W-1:0]   cnt_r;
  logic               sum_last_r;
  logic [RECIP_W-1:0] recip;
  logic [NUM_W-1:0]   num [3];
  logic [PROD_W-1:0]  prod [3];
  logic [CH_W-1:0]    q_r [3];
  logic               q_last_r;
  logic               out_valid_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // effective frame size: zero acts as one, width clamps to the buffer depth
  always_comb begin
    if (fw_r == '0) begin
      eff_w = FW_W'(1);
    end else if (fw_r > FW_MAX) begin
      eff_w = FW_MAX;
    end else begin
      eff_w = fw_r;
    end
    eff_h = (fh_r == '0) ? FH_W'(1) : fh_r;
  end

  // position flags
  assign col_ext  = FW_W'(col_r);
  assign col_inc  = col_ext + FW_W'(1);
  assign drn_ext  = FW_W'(drn_r);
  assign drn_inc  = drn_ext + FW_W'(1);
  assign row_end  = (col_ext == eff_w - FW_W'(1));
  assign col_wrap = (col_inc >= eff_w);
  assign drn_wrap = (drn_inc >= eff_w);

  assign status.out1_en  = (row_r != '0) && (col_r != '0);
  assign status.out2_en  = (row_r != '0) && row_end;
  assign status.drain_ok = (row_r >= eff_h) && (drn_ext < eff_w);
  assign status.out_free = !out_valid_r || !out_stall;

  // registers, counters; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= FW_RESET;
      fh_r  <= FH_RESET;
      col_r <= '0;
      row_r <= '0;
      drn_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
      drn_r <= '0;
    end else begin
      // a pixel after a complete frame opens a new one
      if (cmd.accept_pix && (row_r >= eff_h)) begin
        col_r <= '0;
        row_r <= '0;
        drn_r <= '0;
      end
      if (cmd.adv_pixel) begin
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_r + FH_W'(1);
        end else begin
          col_r <= col_inc[ADDR_W-1:0];
        end
      end
      if (cmd.adv_drain) begin
        if (drn_wrap) begin
          col_r <= '0;
          row_r <= '0;
          drn_r <= '0;
        end else begin
          drn_r <= drn_inc[ADDR_W-1:0];
        end
      end
    end
  end

  // pixel capture
  always_ff @(posedge clk) begin
    if (cmd.accept_pix) begin
      pix_r <= {in_red_in, in_green_in, in_blue_in};
    end
  end

  // line buffer read address
  always_comb begin
    case (cmd.addr_sel)
      ADDR_COL:  rd_addr = col_r;
      ADDR_PREV: rd_addr = drn_r - ADDR_W'(1);
      ADDR_CUR:  rd_addr = drn_r;
      ADDR_NEXT: rd_addr = drn_r + ADDR_W'(1);
      default:   rd_addr = col_r;
    endcase
  end

  // older row takes what the newer row held; newer row takes the pixel
  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk     (clk),
    .wr_en   (cmd.ram_wr),
    .wr_addr (col_r),
    .wr_data (newer_rd),
    .rd_addr (rd_addr),
    .rd_data (older_rd)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
    .clk     (clk),
    .wr_en   (cmd.ram_wr),
    .wr_addr (col_r),
    .wr_data (pix_r),
    .rd_addr (rd_addr),
    .rd_data (newer_rd)
  );

  // window shift: top row from older buffer, middle from newer, bottom pixel
  assign col_in[0] = older_rd;
  assign col_in[1] = newer_rd;
  assign col_in[2] = pix_r;

  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
        win_r[r][2] <= col_in[r];
      end
    end
  end

  // neighbourhood masks: bit 0 top/left, bit 1 middle, bit 2 bottom/right
  always_comb begin
    case (cmd.res_sel)
      RES_FIRST: begin
        rows_m = {1'b1, 1'b1, (row_r >= FH_W'(2))};
        cols_m = {1'b1, 1'b1, (col_r >= ADDR_W'(2))};
        last_m = !row_end;
      end
      RES_SECOND: begin
        rows_m = {1'b1, 1'b1, (row_r >= FH_W'(2))};
        cols_m = {1'b1, (eff_w >= FW_W'(2)), 1'b0};
        last_m = 1'b1;
      end
      RES_DRAIN: begin
        rows_m = {1'b0, 1'b1, (eff_h >= FH_W'(2))};
        cols_m = {(drn_inc < eff_w), 1'b1, (drn_r != '0)};
        last_m = 1'b1;
      end
      default: begin
        rows_m = '0;
        cols_m = '0;
        last_m = 1'b1;
      end
    endcase
  end

  // masked channel sums and neighbour count
  always_comb begin
    cnt_nxt = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rows_m[r] && cols_m[c]) begin
          cnt_nxt = cnt_nxt + CNT_W'(1);
          for (int ch = 0; ch < 3; ch++) begin
            sum_nxt[ch] = sum_nxt[ch] + SUM_W'(win_r[r][c][PIX_W-1-CH_W*ch -: CH_W]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      sum_last_r <= last_m;
    end
  end

  // rounded mean: (2*sum + count) * ceil(2^17 / (2*count)) >> 17
  assign recip = mean_recip(cnt_r);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = NUM_W'({sum_r[ch], 1'b0}) + NUM_W'(cnt_r);
      prod[ch] = PROD_W'(num[ch]) * PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      for (int ch = 0; ch < 3; ch++) begin
        q_r[ch] <= prod[ch][RECIP_SHIFT +: CH_W];
      end
      q_last_r <= sum_last_r;
    end
  end

  // output register: cleared by a transfer, refilled by the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red_out   <= q_r[0];
      out_green_out <= q_r[1];
      out_blue_out  <= q_r[2];
      out_last      <= q_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
